### rtl/sha256_block_compress_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros shared by the SHA-256 block compress RTL
// Both macros sample on clk and are disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef SHA256_BLOCK_COMPRESS_DEFINES_SVH
`define SHA256_BLOCK_COMPRESS_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define S256BC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define S256BC_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define S256BC_ASSERT(lbl, prop, msg)
`define S256BC_NEVER(lbl, cond, msg)
`endif

`endif

### rtl/s256bc_pkg.sv
// ---------------------------------------------------------------------------
// s256bc_pkg
// Types, constants and round functions for the SHA-256 block compressor.
// ---------------------------------------------------------------------------
package s256bc_pkg;

    localparam int WORD_W       = 32;
    localparam int BLOCK_WORDS  = 16;
    localparam int ROUNDS       = 64;
    localparam int DIGEST_WORDS = 8;
    localparam int WCNT_W       = $clog2(BLOCK_WORDS);
    localparam int RND_W        = $clog2(ROUNDS);
    localparam int DIDX_W       = $clog2(DIGEST_WORDS);

    // word queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    typedef logic [WORD_W-1:0] word_t;

    // one queued message word, tagged with its end-of-block mark
    typedef struct packed {
        logic  last;
        word_t data;
    } q_entry_t;

    // digest hand-off from the round engine to the output stage
    typedef struct packed {
        logic                         valid;
        logic [DIGEST_WORDS-1:0][WORD_W-1:0] word;
    } dig_load_t;

    localparam word_t INIT_HASH [DIGEST_WORDS] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam word_t ROUND_K [ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic word_t big_sigma0(input word_t x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic word_t big_sigma1(input word_t x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic word_t small_sigma0(input word_t x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ (x >> 3);
    endfunction

    function automatic word_t small_sigma1(input word_t x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ (x >> 10);
    endfunction

endpackage

### rtl/s256bc_front.sv
// ---------------------------------------------------------------------------
// s256bc_front
// Input side: take message words and tag the sixteenth word of each block.
// ---------------------------------------------------------------------------
module s256bc_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  s256bc_pkg::word_t   s_axis_tdata,
    input  logic                q_full,
    output logic                q_push,
    output s256bc_pkg::q_entry_t q_wdata
);
    import s256bc_pkg::*;

    logic [WCNT_W-1:0] wcnt_reg;
    logic [WCNT_W-1:0] wcnt_next;

    assign s_axis_tready = !q_full;
    assign q_push        = s_axis_tvalid && s_axis_tready;
    assign q_wdata.data  = s_axis_tdata;
    assign q_wdata.last  = (wcnt_reg == WCNT_W'(BLOCK_WORDS - 1));

    // wraps at the block boundary
    assign wcnt_next = q_push ? wcnt_reg + WCNT_W'(1) : wcnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wcnt_reg <= '0;
        end
        else
        begin
            wcnt_reg <= wcnt_next;
        end
    end

endmodule

### rtl/s256bc_queue.sv
// ---------------------------------------------------------------------------
// s256bc_queue
// Short word queue that decouples the input side from the round engine.
// ---------------------------------------------------------------------------
`include "sha256_block_compress_defines.svh"

module s256bc_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  s256bc_pkg::q_entry_t wdata,
    output logic                 full,
    input  logic                 pop,
    output logic                 rvalid,
    output s256bc_pkg::q_entry_t rdata
);
    import s256bc_pkg::*;

    q_entry_t          mem_reg [Q_DEPTH];
    logic [Q_AW-1:0]   wr_ptr_reg;
    logic [Q_AW-1:0]   wr_ptr_next;
    logic [Q_AW-1:0]   rd_ptr_reg;
    logic [Q_AW-1:0]   rd_ptr_next;
    logic [Q_CW-1:0]   cnt_reg;
    logic [Q_CW-1:0]   cnt_next;

    assign full   = (cnt_reg == Q_CW'(Q_DEPTH));
    assign rvalid = (cnt_reg != '0);
    assign rdata  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + Q_AW'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + Q_AW'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + Q_CW'(1);
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - Q_CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    `S256BC_NEVER(a_q_no_overflow, push && full, "queue written while full")
    `S256BC_NEVER(a_q_no_underflow, pop && !rvalid, "queue read while empty")

endmodule

### rtl/s256bc_core.sv
// ---------------------------------------------------------------------------
// s256bc_core
// Round engine: collect a block into the schedule window, run 64 rounds,
// hand the finished digest to the output stage.
// ---------------------------------------------------------------------------
`include "sha256_block_compress_defines.svh"

module s256bc_core (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_valid,
    input  s256bc_pkg::q_entry_t  q_rdata,
    output logic                  q_pop,
    input  logic                  out_free,
    output s256bc_pkg::dig_load_t dig_load
);
    import s256bc_pkg::*;

    localparam logic [1:0] ST_LOAD   = 2'd0;
    localparam logic [1:0] ST_ROUND  = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    logic [1:0]       state_reg;
    logic [1:0]       state_next;
    logic [RND_W-1:0] rnd_reg;
    logic [RND_W-1:0] rnd_next;

    // w_reg[0] is the oldest schedule word, i.e. W[t] during round t
    word_t w_reg [BLOCK_WORDS];
    word_t w_next [BLOCK_WORDS];
    word_t v_reg [DIGEST_WORDS];
    word_t v_next [DIGEST_WORDS];

    word_t w_new;
    word_t t1;
    word_t t2;
    word_t ch;
    word_t maj;

    assign w_new = small_sigma1(w_reg[14]) + w_reg[9] + small_sigma0(w_reg[1]) + w_reg[0];
    assign ch    = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
    assign maj   = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
    assign t1    = v_reg[7] + big_sigma1(v_reg[4]) + ch + ROUND_K[rnd_reg] + w_reg[0];
    assign t2    = big_sigma0(v_reg[0]) + maj;

    assign q_pop = (state_reg == ST_LOAD) && q_valid;

    always_comb
    begin
        state_next = state_reg;
        rnd_next   = rnd_reg;
        w_next     = w_reg;
        v_next     = v_reg;
        dig_load.valid = 1'b0;
        for (int i = 0; i < DIGEST_WORDS; i++)
        begin
            dig_load.word[i] = INIT_HASH[i] + v_reg[i];
        end

        case (state_reg)
            ST_LOAD:
            begin
                if (q_pop)
                begin
                    for (int i = 0; i < BLOCK_WORDS - 1; i++)
                    begin
                        w_next[i] = w_reg[i + 1];
                    end
                    w_next[BLOCK_WORDS - 1] = q_rdata.data;
                    if (q_rdata.last)
                    begin
                        for (int i = 0; i < DIGEST_WORDS; i++)
                        begin
                            v_next[i] = INIT_HASH[i];
                        end
                        rnd_next   = '0;
                        state_next = ST_ROUND;
                    end
                end
            end
            ST_ROUND:
            begin
                // advance the window by one expanded word
                for (int i = 0; i < BLOCK_WORDS - 1; i++)
                begin
                    w_next[i] = w_reg[i + 1];
                end
                w_next[BLOCK_WORDS - 1] = w_new;
                v_next[7] = v_reg[6];
                v_next[6] = v_reg[5];
                v_next[5] = v_reg[4];
                v_next[4] = v_reg[3] + t1;
                v_next[3] = v_reg[2];
                v_next[2] = v_reg[1];
                v_next[1] = v_reg[0];
                v_next[0] = t1 + t2;
                rnd_next  = rnd_reg + RND_W'(1);
                if (rnd_reg == RND_W'(ROUNDS - 1))
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                // hold the digest until the output stage has drained
                if (out_free)
                begin
                    dig_load.valid = 1'b1;
                    state_next     = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        w_reg <= w_next;
        v_reg <= v_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            rnd_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            rnd_reg   <= rnd_next;
        end
    end

    `S256BC_ASSERT(a_core_round_end, (state_reg == ST_ROUND && rnd_reg == RND_W'(ROUNDS - 1)) |=> (state_reg == ST_FINISH), "rounds did not end after the last round")
    `S256BC_NEVER(a_core_load_busy, dig_load.valid && !out_free, "digest loaded while output busy")

endmodule

### rtl/s256bc_out.sv
// ---------------------------------------------------------------------------
// s256bc_out
// Output stage: hold one digest and stream its eight words in order.
// ---------------------------------------------------------------------------
module s256bc_out (
    input  logic                        clk,
    input  logic                        rst_n,
    input  s256bc_pkg::dig_load_t       dig_load,
    output logic                        out_free,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output s256bc_pkg::word_t           m_axis_tdata,
    output logic [s256bc_pkg::DIDX_W-1:0] m_axis_tuser,
    output logic                        m_axis_tlast
);
    import s256bc_pkg::*;

    word_t             buf_reg [DIGEST_WORDS];
    word_t             buf_next [DIGEST_WORDS];
    logic              busy_reg;
    logic              busy_next;
    logic [DIDX_W-1:0] idx_reg;
    logic [DIDX_W-1:0] idx_next;
    logic              xfer;

    assign out_free      = !busy_reg;
    assign m_axis_tvalid = busy_reg;
    assign m_axis_tdata  = buf_reg[0];
    assign m_axis_tuser  = idx_reg;
    assign m_axis_tlast  = (idx_reg == DIDX_W'(DIGEST_WORDS - 1));
    assign xfer          = m_axis_tvalid && m_axis_tready;

    always_comb
    begin
        buf_next  = buf_reg;
        busy_next = busy_reg;
        idx_next  = idx_reg;
        if (dig_load.valid)
        begin
            for (int i = 0; i < DIGEST_WORDS; i++)
            begin
                buf_next[i] = dig_load.word[i];
            end
            busy_next = 1'b1;
            idx_next  = '0;
        end
        else if (xfer)
        begin
            // shift the next word into the head position
            for (int i = 0; i < DIGEST_WORDS - 1; i++)
            begin
                buf_next[i] = buf_reg[i + 1];
            end
            idx_next = idx_reg + DIDX_W'(1);
            if (m_axis_tlast)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        buf_reg <= buf_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

endmodule

### rtl/sha256_block_compress.sv
// Flow: the core loads a block's sixteen words from the queue, runs the 64 rounds at
//   one per cycle, then hands the digest to the output stage once that stage is free.
// The core pops no word of the next block until that hand-off, while the queue holds
//   up to four words and the output stage streams the previous digest.
// Reset: rst_n clears the word count, queue, round sequencer and output stage;
//   schedule and working registers are not reset and are fully written before use.
// ---------------------------------------------------------------------------
// sha256_block_compress
// SHA-256 compression of one padded block from the standard initial hash.
// ---------------------------------------------------------------------------
module sha256_block_compress (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  s256bc_pkg::word_t             s_axis_tdata,   // [31:0] message_word
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output s256bc_pkg::word_t             m_axis_tdata,   // [31:0] digest_word
    output logic [s256bc_pkg::DIDX_W-1:0] m_axis_tuser,   // [2:0] digest_index
    output logic                          m_axis_tlast    // last_word
);
    import s256bc_pkg::*;

    logic      q_full;
    logic      q_push;
    q_entry_t  q_wdata;
    logic      q_pop;
    logic      q_valid;
    q_entry_t  q_rdata;
    logic      out_free;
    dig_load_t dig_load;

    s256bc_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_wdata       (q_wdata)
    );

    s256bc_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (q_push),
        .wdata  (q_wdata),
        .full   (q_full),
        .pop    (q_pop),
        .rvalid (q_valid),
        .rdata  (q_rdata)
    );

    s256bc_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_rdata  (q_rdata),
        .q_pop    (q_pop),
        .out_free (out_free),
        .dig_load (dig_load)
    );

    s256bc_out u_out (
        .clk           (clk),
        .rst_n         (rst_n),
        .dig_load      (dig_load),
        .out_free      (out_free),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule
